// ===== sv/pwwa_pkg.sv =====
// pwwa_pkg: sizes, register codes and controller/datapath command types
// for the per-channel weighted window average block. No dependencies.
package pwwa_pkg;

    localparam int NUM_CHANNELS = 64;
    localparam int MAX_WINDOW   = 8;
    localparam int RING_DEPTH   = MAX_WINDOW - 1;
    localparam int NUM_TAPS     = MAX_WINDOW - 1;

    localparam int CH_W       = $clog2(NUM_CHANNELS);
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int HIST_DEPTH = NUM_CHANNELS * RING_DEPTH;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int TIME_W     = 32;
    localparam int CELL_W     = 24;
    localparam int WIN_W      = 4;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = WEIGHT_W + TIME_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS  = TIME_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_0      = 3'd1;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RESET = 4'd8;

    function automatic logic [WEIGHT_W-1:0] tap_reset(input int idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            0:       w = 16'd12851;
            1:       w = 16'd12025;
            2:       w = 16'd11074;
            3:       w = 16'd9947;
            4:       w = 16'd8568;
            5:       w = 16'd6789;
            6:       w = 16'd4283;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    typedef struct packed {
        logic capture;    // latch input word, read head ram
        logic init;       // set up divider, ring pointers, accumulator
        logic div_step;   // one quotient bit
        logic ring_wr;    // write raw value into history ring
        logic head_upd;   // advance head, mark channel primed
        logic mac_issue;  // read one history tap
        logic res_load;   // load output register
    } pwwa_cmd_t;

    typedef struct packed {
        logic wr_last;
        logic use_avg;
        logic tap_last;
        logic out_free;
    } pwwa_sts_t;

endpackage

// ===== sv/pwwa_ram.sv =====
// pwwa_ram: generic single write port, single read port ram with
// registered read data. No dependencies.
module pwwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pwwa_ctrl.sv =====
// pwwa_ctrl: sequencer for one word: setup, bit-serial divide, history
// write, tap reads, pipeline drain, result load. Depends on pwwa_pkg.
module pwwa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pwwa_pkg::pwwa_sts_t sts,
    output pwwa_pkg::pwwa_cmd_t cmd
);
    import pwwa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_DIV,
        S_WRITE,
        S_MAC,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.ring_wr = 1'b1;
                if (sts.wr_last)
                begin
                    cmd.head_upd = 1'b1;
                    state_next   = sts.use_avg ? S_MAC : S_DONE;
                end
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (sts.tap_last)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // read data, then product, then accumulate
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sv/pwwa_dp.sv =====
// pwwa_dp: config registers, restoring divider, history and head rams,
// multiply-accumulate pipeline and output register. Depends on pwwa_pkg,
// pwwa_ram.
module pwwa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pwwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwwa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [pwwa_pkg::CH_W-1:0]         proc_index,
    input  logic [pwwa_pkg::TIME_W-1:0]       total_time,
    input  logic [pwwa_pkg::CELL_W-1:0]       cell_count,
    input  pwwa_pkg::pwwa_cmd_t               cmd,
    output pwwa_pkg::pwwa_sts_t               sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pwwa_pkg::CH_W-1:0]         out_proc_index,
    output logic [pwwa_pkg::TIME_W-1:0]       avg_time_per_cell,
    output logic                              saturated
);
    import pwwa_pkg::*;

    // configuration
    logic [WIN_W-1:0]    window_len_reg;
    logic [WEIGHT_W-1:0] tap_reg [NUM_TAPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                tap_reg[i] <= tap_reset(i);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WINDOW_LEN)
            begin
                window_len_reg <= cfg_data[WIN_W-1:0];
            end
            else
            begin
                tap_reg[cfg_index - CFG_TAP_0] <= cfg_data[WEIGHT_W-1:0];
            end
        end
    end

    // input word
    logic [CH_W-1:0]   ch_reg;
    logic [TIME_W-1:0] total_reg;
    logic [CELL_W-1:0] cells_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg    <= proc_index;
            total_reg <= total_time;
            cells_reg <= cell_count;
        end
    end

    // per-channel primed flags gate the head ram contents
    logic [NUM_CHANNELS-1:0] primed_reg;
    logic [SLOT_W-1:0]       head_rdata;
    logic [SLOT_W-1:0]       head_reg;
    logic [SLOT_W-1:0]       head_inc;
    logic                    primed_cur_reg;

    assign head_inc = (head_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    pwwa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_CHANNELS)
    ) u_head_ram (
        .clk   (clk),
        .we    (cmd.head_upd),
        .waddr (ch_reg),
        .wdata (head_inc),
        .re    (cmd.capture),
        .raddr (proc_index),
        .rdata (head_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= '0;
        end
        else if (cmd.head_upd)
        begin
            primed_reg[ch_reg] <= 1'b1;
        end
    end

    // restoring divide of total*2^16 by cells, one quotient bit a cycle
    logic [CELL_W-1:0] rem_reg;
    logic [TIME_W-1:0] dsh_reg;
    logic [TIME_W-1:0] quo_reg;
    logic              sat_reg;
    logic [CELL_W:0]   trial;
    logic [CELL_W:0]   diff;
    logic              trial_ge;
    logic [TIME_W-1:0] raw;

    assign trial    = {rem_reg, dsh_reg[TIME_W-1]};
    assign diff     = trial - {1'b0, cells_reg};
    assign trial_ge = trial >= {1'b0, cells_reg};
    assign raw      = sat_reg ? '1 : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            // high quotient half is zero unless the value overflows
            rem_reg <= CELL_W'(total_reg[TIME_W-1:FRAC_W]);
            dsh_reg <= {total_reg[FRAC_W-1:0], {FRAC_W{1'b0}}};
            sat_reg <= CELL_W'(total_reg[TIME_W-1:FRAC_W]) >= cells_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
            dsh_reg <= {dsh_reg[TIME_W-2:0], 1'b0};
            quo_reg <= {quo_reg[TIME_W-2:0], trial_ge};
        end
    end

    // history ring addressing
    logic [SLOT_W-1:0]  wr_slot_reg;
    logic [SLOT_W-1:0]  rd_slot_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic [SLOT_W-1:0]  wr_slot;
    logic [HIST_AW-1:0] ring_base;
    logic [TIME_W-1:0]  hist_rdata;
    logic [SLOT_W-1:0]  last_tap;

    assign ring_base = HIST_AW'(ch_reg) * HIST_AW'(RING_DEPTH);
    assign wr_slot   = primed_cur_reg ? head_reg : wr_slot_reg;
    assign last_tap  = (window_len_reg >= WIN_W'(NUM_TAPS)) ? SLOT_W'(NUM_TAPS - 1)
                                                            : SLOT_W'(window_len_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            head_reg       <= primed_reg[ch_reg] ? head_rdata : '0;
            rd_slot_reg    <= primed_reg[ch_reg] ? head_rdata : '0;
            primed_cur_reg <= primed_reg[ch_reg];
            wr_slot_reg    <= '0;
            k_reg          <= '0;
        end
        else
        begin
            if (cmd.ring_wr)
            begin
                wr_slot_reg <= wr_slot_reg + 1'b1;
            end
            if (cmd.mac_issue)
            begin
                // walk back from the newest sample
                rd_slot_reg <= (rd_slot_reg == '0) ? SLOT_W'(RING_DEPTH - 1)
                                                   : rd_slot_reg - 1'b1;
                k_reg       <= k_reg + 1'b1;
            end
        end
    end

    pwwa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.ring_wr),
        .waddr (ring_base + HIST_AW'(wr_slot)),
        .wdata (raw),
        .re    (cmd.mac_issue),
        .raddr (ring_base + HIST_AW'(rd_slot_reg)),
        .rdata (hist_rdata)
    );

    // multiply-accumulate pipeline: read, product, accumulate
    logic                v1_reg, v2_reg;
    logic [SLOT_W-1:0]   k1_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [WEIGHT_W-1:0] weight_sel;

    always_comb
    begin
        weight_sel = '0;
        if (k1_reg < SLOT_W'(NUM_TAPS))
        begin
            weight_sel = tap_reg[k1_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_issue)
        begin
            k1_reg <= k_reg;
        end
        if (v1_reg)
        begin
            prod_reg <= PROD_W'(weight_sel) * PROD_W'(hist_rdata);
        end
        if (cmd.init)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, clamp
    logic [ACC_W-1:0]  acc_rnd;
    logic [TIME_W-1:0] result;
    logic              use_avg;

    assign use_avg = window_len_reg > WIN_W'(1);
    assign acc_rnd = acc_reg + ACC_W'(1 << (FRAC_W - 1));

    always_comb
    begin
        if (!use_avg)
        begin
            result = raw;
        end
        else if (|acc_rnd[ACC_W-1:FRAC_W+TIME_W])
        begin
            result = '1;
        end
        else
        begin
            result = acc_rnd[FRAC_W+TIME_W-1:FRAC_W];
        end
    end

    // output register
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_ch_reg;
    logic [TIME_W-1:0] out_avg_reg;
    logic              out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_ch_reg  <= ch_reg;
            out_avg_reg <= result;
            out_sat_reg <= sat_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_proc_index    = out_ch_reg;
    assign avg_time_per_cell = out_avg_reg;
    assign saturated         = out_sat_reg;

    assign sts.wr_last  = primed_cur_reg || (wr_slot_reg == SLOT_W'(RING_DEPTH - 1));
    assign sts.use_avg  = use_avg;
    assign sts.tap_last = k_reg == last_tap;
    assign sts.out_free = !out_valid_reg || out_ready;

    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat_reg) |-> (rem_reg < cells_reg))
        else $error("divider remainder not below divisor");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken word");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!v1_reg && !v2_reg))
        else $error("result loaded before accumulate pipeline drained");

    a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (k1_reg < SLOT_W'(NUM_TAPS)))
        else $error("tap index past last weight");

    a_primed_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_upd |=> primed_reg[ch_reg])
        else $error("channel not primed after head update");

endmodule

// ===== sv/per_channel_weighted_window_average.sv =====
// per_channel_weighted_window_average: top level, joins the sequencer and
// the datapath. Depends on pwwa_pkg, pwwa_ctrl, pwwa_dp (and pwwa_ram).
//
//  channel  signals                                              handshake
//  in       proc_index, total_time, cell_count                  in_valid / in_ready
//  out      out_proc_index, avg_time_per_cell, saturated        out_valid / out_ready
//  cfg      cfg_index, cfg_data                                  cfg_we, no wait
//
// one word at a time: accept, setup and bit-serial divide, then history
// writes (all 7 ring slots on a channel's first word, one afterwards), then
// for a window above one, one read per tap (2 to 7) plus pipeline drain,
// then result load; the word rate is set by the bit-serial divider and the
// single history ram read port.
// reset clears config to defaults and all channels to unprimed; no ram sweep.
// a stalled output holds; the next word is taken meanwhile and waits to load.
module per_channel_weighted_window_average (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pwwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwwa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pwwa_pkg::CH_W-1:0]       proc_index,
    input  logic [pwwa_pkg::TIME_W-1:0]     total_time,
    input  logic [pwwa_pkg::CELL_W-1:0]     cell_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pwwa_pkg::CH_W-1:0]       out_proc_index,
    output logic [pwwa_pkg::TIME_W-1:0]     avg_time_per_cell,
    output logic                            saturated
);
    import pwwa_pkg::*;

    pwwa_cmd_t cmd;
    pwwa_sts_t sts;

    pwwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwwa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .proc_index        (proc_index),
        .total_time        (total_time),
        .cell_count        (cell_count),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_proc_index    (out_proc_index),
        .avg_time_per_cell (avg_time_per_cell),
        .saturated         (saturated)
    );

endmodule
